/* rtl/sctt_pkg.sv */
// sctt_pkg: shared types and codes for the sorted cue timeline table.
// No dependencies; used by sorted_cue_timeline_table_unit and test/tb.sv.

package sctt_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned CueW          = 16;
  localparam int unsigned LevelW        = 16;
  localparam int unsigned EntryW        = CueW + LevelW;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_QUERY   = 3'd2,
    OP_SET_CUR = 3'd3,
    OP_ADVANCE = 3'd4,
    OP_RETREAT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]        op;
    logic [CueW-1:0]   cue;
    logic [LevelW-1:0] level;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LevelW-1:0] level_at_cue;
    logic              move_present;
    logic              next_found;
    logic [CueW-1:0]   next_cue;
    logic [LevelW-1:0] next_level;
    logic              before_found;
    logic [CueW-1:0]   before_cue;
    logic [LevelW-1:0] before_level;
    logic              cursor_valid;
    logic [LevelW-1:0] cursor_level;
  } out_word_t;

endpackage

/* rtl/sctt_ram.sv */
// sctt_ram: one write port, one read port, registered read data.
// Depends on nothing; instantiated by sorted_cue_timeline_table_unit.

module sctt_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Aw    = 6,
  parameter int unsigned Dw    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [Dw-1:0] wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [Dw-1:0] rdata_o
);

  logic [Dw-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/sorted_cue_timeline_table_unit.sv */
// sorted_cue_timeline_table_unit: top level, sequencer around the entry RAM.
// Depends on sctt_pkg and sctt_ram.
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+------------------------
//   in      | input     | in_valid / stall   | sctt_pkg::in_word_t
//   out     | output    | out_valid / stall  | sctt_pkg::out_word_t
//   cfg     | input     | cfg_valid / ready  | home_level, 16 bit
//
// One word at a time, in steps: scan, decide, shift, new-entry write, cursor
// read, output load. The slowest word is an insert at the front of the table.
// Reset clears count, cursor and home level; RAM contents are never cleared.
// A result waits in the output register under out stall; the next word is
// taken meanwhile, and the sequencer only holds at its last step.

module sorted_cue_timeline_table_unit #(
  parameter int unsigned TableDepth = sctt_pkg::TableDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  sctt_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output sctt_pkg::out_word_t            out_word_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sctt_pkg::LevelW-1:0]    cfg_data_i
);

  localparam int unsigned Aw = $clog2(TableDepth);
  localparam int unsigned Cw = $clog2(TableDepth + 1);
  localparam int unsigned Ew = sctt_pkg::EntryW;
  localparam int unsigned Lw = sctt_pkg::LevelW;
  localparam int unsigned Qw = sctt_pkg::CueW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_WRNEW  = 3'd4;
  localparam logic [2:0] S_CREAD  = 3'd5;
  localparam logic [2:0] S_CWAIT  = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]    state_q;
  logic [2:0]    op_q;
  logic [Qw-1:0] cue_q;
  logic [Lw-1:0] lvl_q;
  logic [Lw-1:0] home_q;
  logic [Cw-1:0] cnt_q;
  logic [Aw-1:0] cidx_q;
  logic          cset_q;
  // scan
  logic [Cw-1:0] scan_q;
  logic          pend_q;
  logic [Aw-1:0] pidx_q;
  logic [Cw-1:0] le_q, lt_q;
  logic [Lw-1:0] floor_lvl_q;
  logic          nf_q;
  logic [Ew-1:0] nxt_q, bef_q;
  logic [Qw-1:0] cue0_q;
  // shift
  logic [Aw-1:0] src_q, psrc_q, pos_q;
  logic [Cw-1:0] rem_q;
  // result
  sctt_pkg::out_word_t res_q;
  sctt_pkg::out_word_t out_q;
  logic                out_valid_q;

  logic          accept;
  logic          ram_we;
  logic [Aw-1:0] ram_waddr, ram_raddr;
  logic [Ew-1:0] ram_wdata, ram_rdata;
  logic [Qw-1:0] rd_cue;
  logic [Cw-1:0] ins_pos;
  logic          out_free;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign rd_cue      = ram_rdata[Ew-1 -: Qw];

  // equal to the first cue with nothing smaller: lands after the first entry
  assign ins_pos = (lt_q == '0 && cnt_q != '0 && cue_q == cue0_q) ? Cw'(1) : lt_q;

  always_comb begin
    ram_raddr = scan_q[Aw-1:0];
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = {cue_q, lvl_q};
    unique case (state_q)
      S_SHIFT: begin
        ram_raddr = src_q;
        ram_we    = pend_q;
        ram_waddr = (op_q == sctt_pkg::OP_INSERT) ? psrc_q + Aw'(1) : psrc_q - Aw'(1);
        ram_wdata = ram_rdata;
      end
      S_WRNEW: begin
        ram_we = 1'b1;
      end
      S_CREAD: ram_raddr = cidx_q;
      default: ram_raddr = scan_q[Aw-1:0];
    endcase
  end

  sctt_ram #(
    .Depth(TableDepth),
    .Aw   (Aw),
    .Dw   (Ew)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cidx_q      <= '0;
      cset_q      <= 1'b0;
      home_q      <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        home_q <= cfg_data_i;
      end
      // the final step reloads the output register itself
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q   <= in_word_i.op;
            cue_q  <= in_word_i.cue;
            lvl_q  <= in_word_i.level;
            scan_q <= '0;
            pend_q <= 1'b0;
            le_q   <= '0;
            lt_q   <= '0;
            nf_q   <= 1'b0;
            if (in_word_i.op == sctt_pkg::OP_INSERT && cnt_q == Cw'(TableDepth)) begin
              res_q   <= '{status: sctt_pkg::ST_FULL, default: '0};
              state_q <= S_CREAD;
            end else begin
              res_q <= '0;
              if (in_word_i.op == sctt_pkg::OP_INSERT ||
                  in_word_i.op == sctt_pkg::OP_REMOVE ||
                  in_word_i.op == sctt_pkg::OP_QUERY  ||
                  in_word_i.op == sctt_pkg::OP_SET_CUR) begin
                state_q <= S_SCAN;
              end else begin
                state_q <= S_DECIDE;
              end
            end
          end
        end

        S_SCAN: begin
          // issue one read per cycle, consume the previous one
          if (scan_q < cnt_q) begin
            scan_q <= scan_q + Cw'(1);
            pend_q <= 1'b1;
            pidx_q <= scan_q[Aw-1:0];
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= S_DECIDE;
            end
          end
          if (pend_q) begin
            if (pidx_q == '0) begin
              cue0_q <= rd_cue;
            end
            if (rd_cue <= cue_q) begin
              le_q        <= le_q + Cw'(1);
              floor_lvl_q <= ram_rdata[Lw-1:0];
            end else if (!nf_q) begin
              nf_q  <= 1'b1;
              nxt_q <= ram_rdata;
            end
            if (rd_cue < cue_q) begin
              lt_q  <= lt_q + Cw'(1);
              bef_q <= ram_rdata;
            end
          end
        end

        S_DECIDE: begin
          pend_q <= 1'b0;
          priority case (op_q)
            sctt_pkg::OP_INSERT: begin
              pos_q   <= ins_pos[Aw-1:0];
              src_q   <= Aw'(cnt_q - Cw'(1));
              rem_q   <= cnt_q - ins_pos;
              cnt_q   <= cnt_q + Cw'(1);
              if (cset_q && ins_pos <= Cw'(cidx_q)) begin
                cidx_q <= cidx_q + Aw'(1);
              end
              state_q <= S_SHIFT;
            end
            sctt_pkg::OP_REMOVE: begin
              if (le_q == lt_q) begin
                res_q.status <= sctt_pkg::ST_MISS;
                state_q      <= S_CREAD;
              end else begin
                src_q   <= Aw'(lt_q + Cw'(1));
                rem_q   <= cnt_q - lt_q - Cw'(1);
                cnt_q   <= cnt_q - Cw'(1);
                if (cset_q) begin
                  if (Cw'(cidx_q) == lt_q) begin
                    cset_q <= 1'b0;
                    cidx_q <= '0;
                  end else if (Cw'(cidx_q) > lt_q) begin
                    cidx_q <= cidx_q - Aw'(1);
                  end
                end
                state_q <= S_SHIFT;
              end
            end
            sctt_pkg::OP_QUERY: begin
              res_q.level_at_cue <= (le_q != '0) ? floor_lvl_q : home_q;
              res_q.move_present <= (le_q != lt_q);
              if (le_q != '0 && nf_q) begin
                res_q.next_found <= 1'b1;
                res_q.next_cue   <= nxt_q[Ew-1 -: Qw];
                res_q.next_level <= nxt_q[Lw-1:0];
              end
              if (lt_q != '0) begin
                res_q.before_found <= 1'b1;
                res_q.before_cue   <= bef_q[Ew-1 -: Qw];
                res_q.before_level <= bef_q[Lw-1:0];
              end
              state_q <= S_CREAD;
            end
            sctt_pkg::OP_SET_CUR: begin
              cset_q  <= (le_q != '0);
              cidx_q  <= (le_q != '0) ? Aw'(le_q - Cw'(1)) : '0;
              state_q <= S_CREAD;
            end
            sctt_pkg::OP_ADVANCE: begin
              if (cset_q && (Cw'(cidx_q) + Cw'(1)) < cnt_q) begin
                cidx_q <= cidx_q + Aw'(1);
              end
              state_q <= S_CREAD;
            end
            sctt_pkg::OP_RETREAT: begin
              if (cset_q && cidx_q != '0) begin
                cidx_q <= cidx_q - Aw'(1);
              end
              state_q <= S_CREAD;
            end
            default: state_q <= S_CREAD;
          endcase
        end

        S_SHIFT: begin
          // read src this cycle, write its neighbor next cycle
          if (rem_q != '0) begin
            rem_q  <= rem_q - Cw'(1);
            pend_q <= 1'b1;
            psrc_q <= src_q;
            src_q  <= (op_q == sctt_pkg::OP_INSERT) ? src_q - Aw'(1) : src_q + Aw'(1);
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= (op_q == sctt_pkg::OP_INSERT) ? S_WRNEW : S_CREAD;
            end
          end
        end

        S_WRNEW: state_q <= S_CREAD;

        S_CREAD: begin
          if (cset_q && Cw'(cidx_q) < cnt_q) begin
            state_q <= S_CWAIT;
          end else begin
            res_q.cursor_valid <= 1'b0;
            res_q.cursor_level <= '0;
            state_q            <= S_FIN;
          end
        end

        S_CWAIT: begin
          res_q.cursor_valid <= 1'b1;
          res_q.cursor_level <= ram_rdata[Lw-1:0];
          state_q            <= S_FIN;
        end

        S_FIN: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // count never exceeds the table
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Cw'(TableDepth))
    else $error("entry count overflow");

  // an idle cursor always names a live entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && cset_q) |-> (Cw'(cidx_q) < cnt_q))
    else $error("cursor beyond table");

  // RAM is written only while shifting or placing a new entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SHIFT || state_q == S_WRNEW))
    else $error("stray RAM write");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking bench for sorted_cue_timeline_table_unit.
// Depends on sctt_pkg and the RTL under rtl/; predicts each result word in line.

module tb;

  localparam int Depth = sctt_pkg::TableDepthDef;
  // worst-case time for one word, plus margin
  localparam int Drain = 2 * Depth + 20;
  localparam int HoldCycles = 1500;
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sctt_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sctt_pkg::out_word_t out_word_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sctt_pkg::LevelW-1:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  sorted_cue_timeline_table_unit #(.TableDepth(Depth)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // ---------------- shadow table ----------------
  logic [sctt_pkg::CueW-1:0]   cue_tab [Depth];
  logic [sctt_pkg::LevelW-1:0] lvl_tab [Depth];
  int                          n_entries = 0;
  int                          cur_pos = 0;
  bit                          cur_on = 1'b0;
  logic [sctt_pkg::LevelW-1:0] home_lvl = '0;

  sctt_pkg::out_word_t pending_results[$];
  int        n_fail = 0;
  int        n_words = 0;
  int        n_checked = 0;
  int        n_full = 0;
  int        n_miss = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_req = 1'b0;
  bit        hold_on = 1'b0;

  // leading entries with cue <= q, or < q when strict
  function automatic int lead_count(logic [sctt_pkg::CueW-1:0] q, bit strict);
    int n;
    n = 0;
    while (n < n_entries && (strict ? cue_tab[n] < q : cue_tab[n] <= q)) n++;
    return n;
  endfunction

  task automatic table_step(input sctt_pkg::in_word_t w, output sctt_pkg::out_word_t r);
    int le, lt, pos, i;
    r = '0;
    case (w.op)
      sctt_pkg::OP_INSERT: begin
        if (n_entries >= Depth) begin
          r.status = sctt_pkg::ST_FULL;
        end else begin
          pos = lead_count(w.cue, 1);
          // equal to first cue lands behind the first entry
          if (pos == 0 && n_entries > 0 && w.cue == cue_tab[0]) pos = 1;
          for (i = n_entries; i > pos; i--) begin
            cue_tab[i] = cue_tab[i-1];
            lvl_tab[i] = lvl_tab[i-1];
          end
          cue_tab[pos] = w.cue;
          lvl_tab[pos] = w.level;
          n_entries++;
          if (cur_on && pos <= cur_pos) cur_pos++;
        end
      end
      sctt_pkg::OP_REMOVE: begin
        pos = lead_count(w.cue, 1);
        if (pos >= n_entries || cue_tab[pos] != w.cue) begin
          r.status = sctt_pkg::ST_MISS;
        end else begin
          for (i = pos; i + 1 < n_entries; i++) begin
            cue_tab[i] = cue_tab[i+1];
            lvl_tab[i] = lvl_tab[i+1];
          end
          n_entries--;
          if (cur_on) begin
            if (cur_pos == pos) begin
              cur_on = 1'b0;
              cur_pos = 0;
            end else if (cur_pos > pos) begin
              cur_pos--;
            end
          end
        end
      end
      sctt_pkg::OP_QUERY: begin
        le = lead_count(w.cue, 0);
        lt = lead_count(w.cue, 1);
        r.level_at_cue = (le > 0) ? lvl_tab[le-1] : home_lvl;
        r.move_present = (le > lt);
        if (le > 0 && le < n_entries) begin
          r.next_found = 1'b1;
          r.next_cue   = cue_tab[le];
          r.next_level = lvl_tab[le];
        end
        if (lt > 0) begin
          r.before_found = 1'b1;
          r.before_cue   = cue_tab[lt-1];
          r.before_level = lvl_tab[lt-1];
        end
      end
      sctt_pkg::OP_SET_CUR: begin
        le = lead_count(w.cue, 0);
        cur_on  = (le > 0);
        cur_pos = (le > 0) ? le - 1 : 0;
      end
      sctt_pkg::OP_ADVANCE: if (cur_on && cur_pos + 1 < n_entries) cur_pos++;
      sctt_pkg::OP_RETREAT: if (cur_on && cur_pos > 0) cur_pos--;
      default: ;
    endcase
    if (cur_on && cur_pos < n_entries) begin
      r.cursor_valid = 1'b1;
      r.cursor_level = lvl_tab[cur_pos];
    end
  endtask

  // ---------------- sender ----------------
  // Called just after a rising edge; leaves valid high on return.
  task automatic send_word(input logic [2:0] op, input logic [sctt_pkg::CueW-1:0] cue,
                           input logic [sctt_pkg::LevelW-1:0] lvl);
    sctt_pkg::in_word_t  w;
    sctt_pkg::out_word_t r;
    int                  gap;
    w.op = op;
    w.cue = cue;
    w.level = lvl;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    table_step(w, r);
    pending_results.push_back(r);
    n_words++;
    if (r.status == sctt_pkg::ST_FULL) n_full++;
    if (r.status == sctt_pkg::ST_MISS) n_miss++;
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_home(input logic [sctt_pkg::LevelW-1:0] v);
    quiesce();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    home_lvl = v;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------- result checker / receiver stall ----------------
  task automatic chk(input string name, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h, got %0h", name, e, a);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    sctt_pkg::out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        n_fail++;
      end else begin
        e = pending_results.pop_front();
        n_checked++;
        chk("status",       e.status,       out_word_o.status);
        chk("level_at_cue", e.level_at_cue, out_word_o.level_at_cue);
        chk("move_present", e.move_present, out_word_o.move_present);
        chk("next_found",   e.next_found,   out_word_o.next_found);
        chk("next_cue",     e.next_cue,     out_word_o.next_cue);
        chk("next_level",   e.next_level,   out_word_o.next_level);
        chk("before_found", e.before_found, out_word_o.before_found);
        chk("before_cue",   e.before_cue,   out_word_o.before_cue);
        chk("before_level", e.before_level, out_word_o.before_level);
        chk("cursor_valid", e.cursor_valid, out_word_o.cursor_valid);
        chk("cursor_level", e.cursor_level, out_word_o.cursor_level);
      end
    end
    // long hold-off wins over random stalls
    out_stall_i <= hold_on || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off, counted in cycles here
  initial begin : hold_proc
    wait (hold_req);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    send_word(sctt_pkg::OP_QUERY, 16'd100, 16'd0);       // empty table, home level
    send_word(sctt_pkg::OP_SET_CUR, 16'd100, 16'd0);     // no floor entry
    send_word(sctt_pkg::OP_ADVANCE, 16'd0, 16'd0);       // no cursor
    send_word(sctt_pkg::OP_REMOVE, 16'd5, 16'd0);        // miss on empty
    send_word(sctt_pkg::OP_INSERT, 16'd500, 16'h1111);
    send_word(sctt_pkg::OP_INSERT, 16'd500, 16'h2222);   // equal to first cue
    send_word(sctt_pkg::OP_INSERT, 16'd0, 16'hFFFF);     // below first
    send_word(sctt_pkg::OP_INSERT, 16'hFFFF, 16'h0000);
    send_word(sctt_pkg::OP_INSERT, 16'd500, 16'h3333);
    send_word(sctt_pkg::OP_QUERY, 16'd0, 16'd0);
    send_word(sctt_pkg::OP_QUERY, 16'd500, 16'd0);
    send_word(sctt_pkg::OP_QUERY, 16'd499, 16'd0);
    send_word(sctt_pkg::OP_QUERY, 16'hFFFF, 16'd0);      // floor is last entry
    send_word(sctt_pkg::OP_SET_CUR, 16'd500, 16'd0);
    send_word(sctt_pkg::OP_ADVANCE, 16'd0, 16'd0);
    send_word(sctt_pkg::OP_ADVANCE, 16'd0, 16'd0);       // at the end
    send_word(sctt_pkg::OP_INSERT, 16'd1, 16'h4444);     // in front of cursor
    send_word(sctt_pkg::OP_REMOVE, 16'd0, 16'd0);        // in front of cursor
    send_word(sctt_pkg::OP_SET_CUR, 16'd0, 16'd0);
    send_word(sctt_pkg::OP_SET_CUR, 16'd1, 16'd0);
    send_word(sctt_pkg::OP_RETREAT, 16'd0, 16'd0);       // at the front
    send_word(sctt_pkg::OP_REMOVE, 16'd1, 16'd0);        // entry under cursor
    send_word(OpSpare6, 16'hFFFF, 16'hFFFF);
    send_word(OpSpare7, 16'hAAAA, 16'h5555);
    send_word(sctt_pkg::OP_REMOVE, 16'd77, 16'd0);       // miss
  endtask

  task automatic test_full_table();
    int extra;
    // fill up, then two more that must be dropped
    extra = Depth - n_entries + 2;
    for (int i = 0; i < extra; i++)
      send_word(sctt_pkg::OP_INSERT, 16'($urandom_range(40)), 16'($urandom));
    send_word(sctt_pkg::OP_SET_CUR, 16'd20, 16'd0);
    send_word(sctt_pkg::OP_QUERY, 16'd20, 16'd0);
    while (n_entries > 4)
      send_word(sctt_pkg::OP_REMOVE, cue_tab[$urandom_range(n_entries-1)], 16'd0);
  endtask

  // mostly a small cue pool so duplicates, hits and cursor moves happen
  task automatic test_random(input int count);
    logic [sctt_pkg::CueW-1:0] c;
    int pick;
    for (int i = 0; i < count; i++) begin
      c = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(48));
      pick = $urandom_range(99);
      if (pick < 30)      send_word(sctt_pkg::OP_INSERT, c, 16'($urandom));
      else if (pick < 48) send_word(sctt_pkg::OP_REMOVE,
                            (n_entries > 0 && pick < 42) ?
                            cue_tab[$urandom_range(n_entries-1)] : c, 16'($urandom));
      else if (pick < 70) send_word(sctt_pkg::OP_QUERY, c, 16'($urandom));
      else if (pick < 80) send_word(sctt_pkg::OP_SET_CUR, c, 16'($urandom));
      else if (pick < 88) send_word(sctt_pkg::OP_ADVANCE, c, 16'($urandom));
      else if (pick < 96) send_word(sctt_pkg::OP_RETREAT, c, 16'($urandom));
      else                send_word($urandom_range(1) ? OpSpare6 : OpSpare7, c,
                                    16'($urandom));
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++)
      send_word(sctt_pkg::OP_QUERY, 16'($urandom_range(48)), 16'd0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_home(16'hFFFF);
    send_word(sctt_pkg::OP_QUERY, 16'd0, 16'd0);
    test_full_table();
    test_backpressure();
    write_home(16'h0000);
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(60);
    write_home(16'($urandom));
    send_idle_pct = 58; recv_stall_pct = 0;  test_random(60);
    write_home(16'hFFFF);
    send_idle_pct = 0;  recv_stall_pct = 58; test_random(60);
    write_home(16'h8001);
    send_idle_pct = 17; recv_stall_pct = 17; test_random(60);
    quiesce();
    $display("Covered %0d words (%0d full drops, %0d remove misses), %0d results checked,",
             n_words, n_full, n_miss, n_checked);
    $display("over four idle/stall mixes, a long output hold-off and five home levels.");
    if (n_fail == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #6ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/sctt_pkg.sv
rtl/sctt_ram.sv
rtl/sorted_cue_timeline_table_unit.sv
test/tb.sv
